// File: rtl/grid_ray_line_of_sight_core_macros.svh
// Assertion macros for the line-of-sight core.
`ifndef GRID_RAY_LINE_OF_SIGHT_CORE_MACROS_SVH
`define GRID_RAY_LINE_OF_SIGHT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRLOS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grlos: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GRLOS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grlos: next-cycle check failed");

`endif

// File: rtl/grlos_pkg.sv
// Shared types and constants of the line-of-sight core.
package grlos_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int MW_W  = 8;
    localparam int MH_W  = 7;
    localparam int CFG_W = 8;

    localparam int DEF_MAX_COLS    = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_TILE_PIXELS = 32;
    localparam int DEF_STEP_PIXELS = 12;

    // Q.8 positions; magnitude squared is scaled by 2^16 before the root
    localparam int FRAC_BITS  = 8;
    localparam int SCALE_BITS = 2 * FRAC_BITS;
    localparam int M2_W   = 15;
    localparam int RAD_W  = 32;
    localparam int ROOT_W = RAD_W / 2;

    localparam logic [MW_W-1:0] RST_MAP_WIDTH  = 8'd79;
    localparam logic [MH_W-1:0] RST_MAP_HEIGHT = 7'd24;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     go;
        iter_op_t op;
    } iter_req_t;

endpackage

// File: rtl/grid_ray_line_of_sight_core.sv
// Line-of-sight core: tile map store and ray-march query sequencer.
//
// Items come in on start when busy is low. action selects a tile write
// (tile_col, tile_row, open_bit) or a sight query (source, target).
// A write gives no result and never raises busy. A query gives one result
// (stop_col, stop_row, target_seen) marked by done for one cycle; the
// receiver cannot stall. A query with source equal to target does not
// raise busy and answers the cycle after start; any other query raises busy.
// It first runs a 16-step square root and two 32-step divisions in the
// shared iterative unit, then marches in 12-pixel steps: each step adds
// the step to the offsets, then corrects them one tile per axis at a time;
// a step that enters a new tile then does the registered map read and the
// tile look; done rises the cycle after the last tile look.
// Configuration (map_width, map_height) is written on cfg_wen at any edge
// and takes effect once registered, also for a query in progress.
// Reset returns the sizes to 79 x 24 and the sequencer to idle; the map
// bits themselves are not cleared and hold garbage until written.
`include "grid_ray_line_of_sight_core_macros.svh"

module grid_ray_line_of_sight_core #(
    parameter int MAX_COLS    = grlos_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = grlos_pkg::DEF_MAX_ROWS,
    parameter int TILE_PIXELS = grlos_pkg::DEF_TILE_PIXELS,
    parameter int STEP_PIXELS = grlos_pkg::DEF_STEP_PIXELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic                        cfg_addr,
    input  logic [grlos_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [grlos_pkg::COL_W-1:0] tile_col,
    input  logic [grlos_pkg::ROW_W-1:0] tile_row,
    input  logic                        open_bit,
    input  logic [grlos_pkg::COL_W-1:0] source_col,
    input  logic [grlos_pkg::ROW_W-1:0] source_row,
    input  logic [grlos_pkg::COL_W-1:0] target_col,
    input  logic [grlos_pkg::ROW_W-1:0] target_row,
    output logic                        done,
    output logic [grlos_pkg::COL_W-1:0] stop_col,
    output logic [grlos_pkg::ROW_W-1:0] stop_row,
    output logic                        target_seen
);
    import grlos_pkg::*;

    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int AD_W     = $clog2(DEPTH);
    localparam int COL_SPAN = (MAX_COLS > 2**COL_W) ? MAX_COLS : 2**COL_W;
    localparam int ROW_SPAN = (MAX_ROWS > 2**ROW_W) ? MAX_ROWS : 2**ROW_W;
    localparam int CT_W     = $clog2(COL_SPAN + STEP_PIXELS + 2) + 1;
    localparam int RT_W     = $clog2(ROW_SPAN + STEP_PIXELS + 2) + 1;
    localparam int QPIX     = TILE_PIXELS * (2**FRAC_BITS);
    localparam int OF_W     = $clog2((TILE_PIXELS + STEP_PIXELS) * (2**FRAC_BITS) + 1) + 1;
    localparam int ST_W     = $clog2(STEP_PIXELS * (2**FRAC_BITS) + 1) + 1;
    localparam int DVD_W    = $clog2((2**COL_W - 1) * STEP_PIXELS + 1) + SCALE_BITS;
    localparam int PR_W     = DVD_W - SCALE_BITS;
    localparam int AW0      = (RAD_W > DVD_W) ? RAD_W : DVD_W;
    localparam int AW       = AW0 + (AW0 % 2);

    localparam logic signed [OF_W-1:0] Q_OF  = OF_W'(QPIX);
    localparam logic signed [OF_W-1:0] NEG_Q = -Q_OF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DIVX,
        ST_DIVY,
        ST_STEP,
        ST_ADJ,
        ST_LOOK
    } state_t;

    state_t                  state_reg, state_next;
    logic [MW_W-1:0]         width_reg, width_next;
    logic [MH_W-1:0]         height_reg, height_next;
    logic [COL_W-1:0]        sc_reg, sc_next, tc_reg, tc_next;
    logic [ROW_W-1:0]        sr_reg, sr_next, tr_reg, tr_next;
    logic [COL_W-1:0]        adx_reg, adx_next;
    logic [ROW_W-1:0]        ady_reg, ady_next;
    logic                    sx_reg, sx_next, sy_reg, sy_next;
    logic [ROOT_W-1:0]       mag_reg, mag_next;
    logic signed [ST_W-1:0]  stx_reg, stx_next, sty_reg, sty_next;
    logic signed [OF_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic signed [CT_W-1:0]  nc_reg, nc_next, cc_reg, cc_next;
    logic signed [RT_W-1:0]  nr_reg, nr_next, cr_reg, cr_next;
    logic                    inmap_reg, inmap_next;
    logic                    done_reg, done_next;
    logic [COL_W-1:0]        stop_col_reg, stop_col_next;
    logic [ROW_W-1:0]        stop_row_reg, stop_row_next;
    logic                    seen_reg, seen_next;

    iter_req_t               iter_req;
    logic [AW-1:0]           iter_a;
    logic [ROOT_W-1:0]       iter_b;
    logic                    iter_done;
    logic [AW-1:0]           iter_res;

    logic                    map_wen;
    logic [AD_W-1:0]         map_waddr;
    logic [AD_W-1:0]         map_raddr;
    logic                    map_rdata;

    logic                    accept;
    logic                    long_query;
    logic [COL_W-1:0]        adx_in;
    logic [ROW_W-1:0]        ady_in;
    logic [M2_W-1:0]         m2;
    logic [PR_W-1:0]         prod_x, prod_y;
    logic [ST_W-2:0]         quo;
    logic                    x_hi, x_lo, y_hi, y_lo;
    logic                    tile_inmap;
    logic signed [CT_W-1:0]  dcx;
    logic signed [RT_W-1:0]  dcy;
    logic [CT_W-1:0]         acx;
    logic [RT_W-1:0]         acy;
    logic                    reached, open_now;

    grlos_iter #(
        .AW (AW),
        .BW (ROOT_W)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .a      (iter_a),
        .b      (iter_b),
        .done   (iter_done),
        .result (iter_res)
    );

    grlos_map #(
        .DEPTH (DEPTH),
        .AD_W  (AD_W)
    ) u_map (
        .clk   (clk),
        .wen   (map_wen),
        .waddr (map_waddr),
        .wdata (open_bit),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign long_query = accept && (action == ACT_QUERY)
                        && ((source_col != target_col) || (source_row != target_row));

    // tile writes
    assign map_wen   = accept && (action == ACT_WRITE)
                       && (32'(tile_col) < 32'(MAX_COLS))
                       && (32'(tile_row) < 32'(MAX_ROWS));
    assign map_waddr = AD_W'(tile_row) * AD_W'(MAX_COLS) + AD_W'(tile_col);

    // query setup
    assign adx_in = (target_col >= source_col) ? target_col - source_col
                                               : source_col - target_col;
    assign ady_in = (target_row >= source_row) ? target_row - source_row
                                               : source_row - target_row;
    assign m2     = M2_W'(adx_in) * M2_W'(adx_in) + M2_W'(ady_in) * M2_W'(ady_in);
    assign prod_x = PR_W'(adx_reg) * PR_W'(STEP_PIXELS);
    assign prod_y = PR_W'(ady_reg) * PR_W'(STEP_PIXELS);
    assign quo    = iter_res[ST_W-2:0];

    // tile t spans ((t-1)*Q, t*Q]; offset held relative to t*Q, in (-Q, 0]
    assign x_hi = !ox_reg[OF_W-1] && (ox_reg != '0);
    assign x_lo = (ox_reg <= NEG_Q);
    assign y_hi = !oy_reg[OF_W-1] && (oy_reg != '0);
    assign y_lo = (oy_reg <= NEG_Q);

    assign tile_inmap = !nc_reg[CT_W-1] && !nr_reg[RT_W-1]
                        && ($unsigned(nc_reg) < CT_W'(width_reg))
                        && ($unsigned(nr_reg) < RT_W'(height_reg))
                        && ($unsigned(nc_reg) < CT_W'(MAX_COLS))
                        && ($unsigned(nr_reg) < RT_W'(MAX_ROWS));
    assign map_raddr = AD_W'($unsigned(nr_reg)) * AD_W'(MAX_COLS)
                       + AD_W'($unsigned(nc_reg));

    assign dcx      = nc_reg - $signed(CT_W'(sc_reg));
    assign dcy      = nr_reg - $signed(RT_W'(sr_reg));
    assign acx      = dcx[CT_W-1] ? CT_W'(-dcx) : CT_W'(dcx);
    assign acy      = dcy[RT_W-1] ? RT_W'(-dcy) : RT_W'(dcy);
    assign reached  = (acx >= CT_W'(adx_reg)) && (acy >= RT_W'(ady_reg));
    assign open_now = inmap_reg && map_rdata;

    always_comb
    begin
        state_next    = state_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        sc_next       = sc_reg;
        sr_next       = sr_reg;
        tc_next       = tc_reg;
        tr_next       = tr_reg;
        adx_next      = adx_reg;
        ady_next      = ady_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        mag_next      = mag_reg;
        stx_next      = stx_reg;
        sty_next      = sty_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        nc_next       = nc_reg;
        nr_next       = nr_reg;
        cc_next       = cc_reg;
        cr_next       = cr_reg;
        inmap_next    = inmap_reg;
        done_next     = 1'b0;
        stop_col_next = stop_col_reg;
        stop_row_next = stop_row_reg;
        seen_next     = seen_reg;
        iter_req      = '{go: 1'b0, op: OP_SQRT};
        iter_a        = '0;
        iter_b        = '0;

        if (cfg_wen)
        begin
            case (cfg_addr)
                REG_MAP_WIDTH:  width_next  = cfg_wdata;
                REG_MAP_HEIGHT: height_next = cfg_wdata[MH_W-1:0];
                default:        width_next  = width_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_QUERY))
                begin
                    sc_next  = source_col;
                    sr_next  = source_row;
                    tc_next  = target_col;
                    tr_next  = target_row;
                    adx_next = adx_in;
                    ady_next = ady_in;
                    sx_next  = (target_col < source_col);
                    sy_next  = (target_row < source_row);
                    ox_next  = '0;
                    oy_next  = '0;
                    nc_next  = $signed(CT_W'(source_col));
                    nr_next  = $signed(RT_W'(source_row));
                    cc_next  = $signed(CT_W'(source_col));
                    cr_next  = $signed(RT_W'(source_row));
                    if ((adx_in == '0) && (ady_in == '0))
                    begin
                        done_next     = 1'b1;
                        stop_col_next = target_col;
                        stop_row_next = target_row;
                        seen_next     = 1'b1;
                    end
                    else
                    begin
                        iter_req   = '{go: 1'b1, op: OP_SQRT};
                        iter_a     = AW'({m2, {SCALE_BITS{1'b0}}});
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (iter_done)
                begin
                    mag_next   = iter_res[ROOT_W-1:0];
                    iter_req   = '{go: 1'b1, op: OP_DIV};
                    iter_a     = AW'({prod_x, {SCALE_BITS{1'b0}}});
                    iter_b     = iter_res[ROOT_W-1:0];
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (iter_done)
                begin
                    stx_next   = sx_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
                    iter_req   = '{go: 1'b1, op: OP_DIV};
                    iter_a     = AW'({prod_y, {SCALE_BITS{1'b0}}});
                    iter_b     = mag_reg;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (iter_done)
                begin
                    sty_next   = sy_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                ox_next    = ox_reg + OF_W'(stx_reg);
                oy_next    = oy_reg + OF_W'(sty_reg);
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                // one tile of correction per axis per cycle
                if (x_hi)
                begin
                    ox_next = ox_reg - Q_OF;
                    nc_next = nc_reg + CT_W'(1);
                end
                else if (x_lo)
                begin
                    ox_next = ox_reg + Q_OF;
                    nc_next = nc_reg - CT_W'(1);
                end
                if (y_hi)
                begin
                    oy_next = oy_reg - Q_OF;
                    nr_next = nr_reg + RT_W'(1);
                end
                else if (y_lo)
                begin
                    oy_next = oy_reg + Q_OF;
                    nr_next = nr_reg - RT_W'(1);
                end
                if (!x_hi && !x_lo && !y_hi && !y_lo)
                begin
                    if ((nc_reg == cc_reg) && (nr_reg == cr_reg))
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        inmap_next = tile_inmap;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (open_now && reached)
                begin
                    done_next     = 1'b1;
                    stop_col_next = tc_reg;
                    stop_row_next = tr_reg;
                    seen_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (!open_now)
                begin
                    done_next     = 1'b1;
                    stop_col_next = cc_reg[COL_W-1:0];
                    stop_row_next = cr_reg[ROW_W-1:0];
                    seen_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cc_next    = nc_reg;
                    cr_next    = nr_reg;
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            width_reg    <= RST_MAP_WIDTH;
            height_reg   <= RST_MAP_HEIGHT;
            sc_reg       <= '0;
            sr_reg       <= '0;
            tc_reg       <= '0;
            tr_reg       <= '0;
            adx_reg      <= '0;
            ady_reg      <= '0;
            sx_reg       <= 1'b0;
            sy_reg       <= 1'b0;
            mag_reg      <= '0;
            stx_reg      <= '0;
            sty_reg      <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            nc_reg       <= '0;
            nr_reg       <= '0;
            cc_reg       <= '0;
            cr_reg       <= '0;
            inmap_reg    <= 1'b0;
            done_reg     <= 1'b0;
            stop_col_reg <= '0;
            stop_row_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            sc_reg       <= sc_next;
            sr_reg       <= sr_next;
            tc_reg       <= tc_next;
            tr_reg       <= tr_next;
            adx_reg      <= adx_next;
            ady_reg      <= ady_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            mag_reg      <= mag_next;
            stx_reg      <= stx_next;
            sty_reg      <= sty_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            nc_reg       <= nc_next;
            nr_reg       <= nr_next;
            cc_reg       <= cc_next;
            cr_reg       <= cr_next;
            inmap_reg    <= inmap_next;
            done_reg     <= done_next;
            stop_col_reg <= stop_col_next;
            stop_row_reg <= stop_row_next;
            seen_reg     <= seen_next;
        end
    end

    assign done        = done_reg;
    assign stop_col    = stop_col_reg;
    assign stop_row    = stop_row_reg;
    assign target_seen = seen_reg;

    `GRLOS_ASSERT_NOW(a_done_idle, done, !busy)
    `GRLOS_ASSERT_NEXT(a_query_busy, long_query, busy)
    `GRLOS_ASSERT_NOW(a_look_after_adj, state_reg == ST_LOOK, $past(state_reg) == ST_ADJ)
    `GRLOS_ASSERT_NOW(a_ofs_settled, state_reg == ST_STEP, !x_hi && !x_lo && !y_hi && !y_lo)

endmodule

// File: rtl/grlos_map.sv
// Passable-bit tile store: one write port, one registered read port.
module grlos_map #(
    parameter int DEPTH = 8192,
    parameter int AD_W  = 13
) (
    input  logic            clk,
    input  logic            wen,
    input  logic [AD_W-1:0] waddr,
    input  logic            wdata,
    input  logic [AD_W-1:0] raddr,
    output logic            rdata
);
    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/grlos_iter.sv
// Shared iterative unit: digit-by-digit square root and restoring division.
module grlos_iter #(
    parameter int AW = 32,
    parameter int BW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  grlos_pkg::iter_req_t req,
    input  logic [AW-1:0]       a,
    input  logic [BW-1:0]       b,
    output logic                done,
    output logic [AW-1:0]       result
);
    import grlos_pkg::*;

    localparam int SUB_W = AW / 2 + 3;
    localparam int CNT_W = $clog2(AW + 1);

    logic             busy_reg;
    logic             done_reg;
    iter_op_t         op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    acc_reg;
    logic [SUB_W-1:0] rem_reg;
    logic [AW-1:0]    q_reg;
    logic [BW-1:0]    div_reg;

    logic [SUB_W-1:0] rem_sh;
    logic [SUB_W-1:0] trial;
    logic [SUB_W:0]   diff;
    logic             take;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh = {rem_reg[SUB_W-3:0], acc_reg[AW-1:AW-2]};
            trial  = {q_reg[SUB_W-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[SUB_W-2:0], acc_reg[AW-1]};
            trial  = SUB_W'(div_reg);
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        take = !diff[SUB_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_SQRT;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_SQRT) ? CNT_W'(AW / 2) : CNT_W'(AW);
                acc_reg  <= a;
                rem_reg  <= '0;
                q_reg    <= '0;
                div_reg  <= b;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? diff[SUB_W-1:0] : rem_sh;
                q_reg   <= {q_reg[AW-2:0], take};
                acc_reg <= (op_reg == OP_SQRT) ? {acc_reg[AW-3:0], 2'b00}
                                               : {acc_reg[AW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

// File: test/tb.sv
// Self-checking testbench for the grid line-of-sight ray-march core.
`timescale 1ns / 1ps

module tb;
    import grlos_pkg::*;

    localparam int FILL_COLS = 40;
    localparam int FILL_ROWS = 16;

    typedef struct {
        logic             action;
        logic [COL_W-1:0] tile_col;
        logic [ROW_W-1:0] tile_row;
        logic             open_bit;
        logic [COL_W-1:0] source_col;
        logic [ROW_W-1:0] source_row;
        logic [COL_W-1:0] target_col;
        logic [ROW_W-1:0] target_row;
    } los_item_t;

    typedef struct {
        logic [COL_W-1:0] stop_col;
        logic [ROW_W-1:0] stop_row;
        logic             target_seen;
        bit               blind;
    } sight_t;

    class sight_scoreboard;
        bit     open_map [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
        bit     known_map [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
        bit     blind_hit;
        longint width_cfg;
        longint height_cfg;
        sight_t pending [$];
        string  msg;

        function void reset_state();
            width_cfg  = RST_MAP_WIDTH;
            height_cfg = RST_MAP_HEIGHT;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_MAP_WIDTH)
                width_cfg = val;
            else
                height_cfg = val & 8'h7F;
        endfunction

        function longint sqrt_floor(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v)
                b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint tile_idx(longint p);
            longint q;
            q = DEF_TILE_PIXELS * 256;
            if (p > 0)
                return (p + q - 1) / q;
            return -((-p) / q);
        endfunction

        // An in-map tile never written makes the answer undefined.
        function bit passable(longint c, longint r);
            if (c < 0 || r < 0 || c >= width_cfg || r >= height_cfg)
                return 0;
            if (c >= DEF_MAX_COLS || r >= DEF_MAX_ROWS)
                return 0;
            if (!known_map[r * DEF_MAX_COLS + c])
                blind_hit = 1'b1;
            return open_map[r * DEF_MAX_COLS + c];
        endfunction

        function longint absl(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Called once per accepted transfer; writes update the map, queries queue an answer.
        function void note_item(los_item_t it);
            longint sc, sr, tc, tr, dx, dy, mag, stx, sty, px, py, cc, cr, nc, nr;
            sight_t ans;
            bit     ok;
            if (it.action == ACT_WRITE)
            begin
                open_map[it.tile_row * DEF_MAX_COLS + it.tile_col]  = it.open_bit;
                known_map[it.tile_row * DEF_MAX_COLS + it.tile_col] = 1'b1;
                return;
            end
            blind_hit = 1'b0;
            sc = it.source_col;
            sr = it.source_row;
            tc = it.target_col;
            tr = it.target_row;
            dx = tc - sc;
            dy = tr - sr;
            ans.stop_col    = it.target_col;
            ans.stop_row    = it.target_row;
            ans.target_seen = 1'b1;
            if (dx != 0 || dy != 0)
            begin
                mag = sqrt_floor((dx * dx + dy * dy) * 65536);
                stx = dx * DEF_STEP_PIXELS * 65536 / mag;
                sty = dy * DEF_STEP_PIXELS * 65536 / mag;
                px  = sc * DEF_TILE_PIXELS * 256;
                py  = sr * DEF_TILE_PIXELS * 256;
                cc  = sc;
                cr  = sr;
                forever
                begin
                    do
                    begin
                        px += stx;
                        py += sty;
                        nc = tile_idx(px);
                        nr = tile_idx(py);
                    end while (nc == cc && nr == cr);
                    ok = passable(nc, nr);
                    if (ok && absl(nc - sc) >= absl(dx) && absl(nr - sr) >= absl(dy))
                        break;
                    if (!ok)
                    begin
                        ans.stop_col    = cc[COL_W-1:0];
                        ans.stop_row    = cr[ROW_W-1:0];
                        ans.target_seen = 1'b0;
                        break;
                    end
                    cc = nc;
                    cr = nr;
                end
            end
            ans.blind = blind_hit;
            pending = {pending, ans};
        endfunction

        // Returns 1 on a mismatch, with the reason in msg.
        function bit check(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic seen);
            sight_t e;
            if (pending.size() == 0)
            begin
                msg = $sformatf("unexpected result col=%0d row=%0d seen=%0d", col, row, seen);
                return 1;
            end
            e = pending.pop_front();
            if (e.blind)
                return 0;
            if (col !== e.stop_col || row !== e.stop_row || seen !== e.target_seen)
            begin
                msg = $sformatf("got col=%0d row=%0d seen=%0d, want col=%0d row=%0d seen=%0d",
                                col, row, seen, e.stop_col, e.stop_row, e.target_seen);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             start;
    logic             busy;
    logic             action;
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic             open_bit;
    logic [COL_W-1:0] source_col;
    logic [ROW_W-1:0] source_row;
    logic [COL_W-1:0] target_col;
    logic [ROW_W-1:0] target_row;
    logic             done;
    logic [COL_W-1:0] stop_col;
    logic [ROW_W-1:0] stop_row;
    logic             target_seen;

    sight_scoreboard sb;
    int              mismatches;
    longint          cycles;
    bit              no_idle;

    grid_ray_line_of_sight_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .action(action),
        .tile_col(tile_col), .tile_row(tile_row), .open_bit(open_bit),
        .source_col(source_col), .source_row(source_row),
        .target_col(target_col), .target_row(target_row),
        .done(done), .stop_col(stop_col), .stop_row(stop_row), .target_seen(target_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report(string s);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycles, s);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 12000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sb.check(stop_col, stop_row, target_seen))
                report(sb.msg);
        end
    end

    task automatic send(los_item_t it, int gap);
        start      <= 1'b1;
        action     <= it.action;
        tile_col   <= it.tile_col;
        tile_row   <= it.tile_row;
        open_bit   <= it.open_bit;
        source_col <= it.source_col;
        source_row <= it.source_row;
        target_col <= it.target_col;
        target_row <= it.target_row;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [CFG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic los_item_t make_write(int c, int r, bit ob);
        los_item_t it;
        it = '{default: '0};
        it.action     = ACT_WRITE;
        it.tile_col   = COL_W'(c);
        it.tile_row   = ROW_W'(r);
        it.open_bit   = ob;
        it.source_col = COL_W'($urandom);
        it.source_row = ROW_W'($urandom);
        it.target_col = COL_W'($urandom);
        it.target_row = ROW_W'($urandom);
        return it;
    endfunction

    function automatic los_item_t make_query(int sc, int sr, int tc, int tr);
        los_item_t it;
        it.action     = ACT_QUERY;
        it.tile_col   = COL_W'($urandom);
        it.tile_row   = ROW_W'($urandom);
        it.open_bit   = 1'($urandom);
        it.source_col = COL_W'(sc);
        it.source_row = ROW_W'(sr);
        it.target_col = COL_W'(tc);
        it.target_row = ROW_W'(tr);
        return it;
    endfunction

    function automatic los_item_t random_item();
        int w, h, sc, sr;
        w = int'(sb.width_cfg);
        h = int'(sb.height_cfg);
        // keep most rays over the tiles that hold known values
        if (w > FILL_COLS)
            w = FILL_COLS;
        if (h > FILL_ROWS)
            h = FILL_ROWS;
        if ($urandom_range(0, 9) < 3)
            return make_write($urandom_range(0, 127), $urandom_range(0, 63),
                              $urandom_range(0, 9) < 8);
        if ($urandom_range(0, 9) == 0)
            return make_query($urandom_range(0, 127), $urandom_range(0, 63),
                              $urandom_range(0, 127), $urandom_range(0, 63));
        sc = $urandom_range(0, w - 1);
        sr = $urandom_range(0, h - 1);
        // short rays stay mostly inside open ground and reach the target
        if ($urandom_range(0, 1))
            return make_query(sc, sr,
                              (sc + $urandom_range(0, 12) + 122) % 128,
                              (sr + $urandom_range(0, 12) + 58) % 64);
        return make_query(sc, sr, $urandom_range(0, w - 1), $urandom_range(0, h - 1));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i == n / 2)
                drain();
            send(random_item(), draw_gap());
        end
        drain();
    endtask

    initial
    begin
        sb         = new();
        mismatches = 0;
        cycles     = 0;
        no_idle    = 0;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_addr   = REG_MAP_WIDTH;
        cfg_wdata  = '0;
        start      = 1'b0;
        action     = ACT_WRITE;
        tile_col   = '0;
        tile_row   = '0;
        open_bit   = 1'b0;
        source_col = '0;
        source_row = '0;
        target_col = '0;
        target_row = '0;
        sb.reset_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner of the store that most queries walk gets known values
        for (int r = 0; r < FILL_ROWS; r++)
            for (int c = 0; c < FILL_COLS; c++)
                send(make_write(c, r, $urandom_range(0, 9) < 8), 0);
        drain();

        // directed, reset sizes 79 x 24
        send(make_write(0, 0, 1), 0);
        send(make_write(78, 23, 1), 0);
        send(make_write(127, 63, 1), 1);
        send(make_write(5, 5, 0), 2);
        send(make_query(3, 3, 3, 3), 0);
        send(make_query(127, 63, 127, 63), 3);
        send(make_query(0, 0, 78, 23), 0);
        send(make_query(78, 23, 0, 0), 5);
        send(make_query(0, 0, 0, 23), 0);
        send(make_query(0, 0, 78, 0), 0);
        send(make_query(5, 0, 5, 10), 0);
        send(make_query(100, 40, 70, 20), 0);
        send(make_query(127, 63, 0, 0), 0);
        send(make_query(78, 0, 127, 63), 0);
        send(make_query(10, 10, 11, 11), 2);
        send(make_query(0, 0, 1, 0), 0);
        drain();

        random_phase(200);
        cfg_write(REG_MAP_WIDTH, 8'd128);
        cfg_write(REG_MAP_HEIGHT, 8'd64);
        send(make_query(0, 0, 127, 63), 0);
        send(make_query(127, 63, 0, 0), 0);
        send(make_query(127, 0, 0, 63), 0);
        random_phase(300);
        cfg_write(REG_MAP_WIDTH, 8'd1);
        cfg_write(REG_MAP_HEIGHT, 8'd1);
        random_phase(100);
        cfg_write(REG_MAP_WIDTH, 8'd17);
        cfg_write(REG_MAP_HEIGHT, 8'd13);
        random_phase(150);
        cfg_write(REG_MAP_WIDTH, 8'd40);
        cfg_write(REG_MAP_HEIGHT, 8'd9);
        random_phase(150);
        cfg_write(REG_MAP_WIDTH, 8'($urandom_range(1, FILL_COLS)));
        cfg_write(REG_MAP_HEIGHT, 8'($urandom_range(1, FILL_ROWS)));
        random_phase(300);

        repeat (2000) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
